@@ hw/rtl/mjdcal_pkg.sv @@
// ----------------------------------------------------------------------------
// mjdcal_pkg: shared types and constants for the MJD to calendar converter
// Item layout between front and back, fixed field widths and the scaled
// integer constants of the date conversion.
// ----------------------------------------------------------------------------
package mjdcal_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned MJD_W  = 19;
    localparam int unsigned FRAC_W = 32;
    localparam int unsigned Z_W    = 22;

    // Whole Julian day from MJD, last day of the Julian calendar
    localparam logic [22:0] MJD_OFFSET  = 23'd2400001;
    localparam logic [21:0] JULIAN_LAST = 22'd2299160;

    // alpha = (4Z - ALPHA_BIAS) / ALPHA_DIV
    localparam logic [23:0] ALPHA_BIAS = 24'd7468865;
    localparam logic [17:0] ALPHA_DIV  = 18'd146097;
    localparam logic [10:0] C_OFS      = 11'd1524;
    // D = (20C - D_BIAS) / D_DIV
    localparam logic [11:0] D_BIAS = 12'd2442;
    localparam logic [12:0] D_DIV  = 13'd7305;
    // G = G_MUL*(C-E) / G_DIV
    localparam logic [13:0] G_MUL = 14'd10000;
    localparam logic [18:0] G_DIV = 19'd306001;

    // Reciprocals floor(2^32 / divisor); K4 and K5 fold the leading multiply in
    localparam logic [14:0] C_M1 = 15'((64'd1 << 32) / 64'd146097);
    localparam logic [19:0] C_M2 = 20'((64'd1 << 32) / 64'd7305);
    localparam logic [27:0] C_K4 = 28'(((64'd1 << 32) / 64'd306001) * 64'd10000);
    localparam logic [36:0] C_K5 = 37'(((64'd1 << 32) / 64'd10000) * 64'd306001);

    typedef struct packed {
        logic [Z_W-1:0]    z;
        logic              jul;
        logic [FRAC_W-1:0] frac;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ hw/rtl/mjdcal_front.sv @@
// ----------------------------------------------------------------------------
// mjdcal_front: input stage
// Accepts an item, forms the whole Julian day and flags the Julian-calendar
// branch, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mjdcal_front
    import mjdcal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MJD_W-1:0]  i_mjd_day,
    input  logic [FRAC_W-1:0] i_day_fraction,
    input  t_qstat            i_qstat,
    output logic              o_push,
    output t_item             o_item
);

    logic        r_vld;
    t_item       r_item;
    logic [22:0] w_z_full;

    assign w_z_full = {{(23 - MJD_W){i_mjd_day[MJD_W-1]}}, i_mjd_day} + MJD_OFFSET;

    assign o_push  = r_vld && !i_qstat.full;
    assign o_stall = r_vld && i_qstat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.z    <= w_z_full[Z_W-1:0];
            r_item.jul  <= (w_z_full[Z_W-1:0] <= JULIAN_LAST);
            r_item.frac <= i_day_fraction;
        end
    end

endmodule

@@ hw/rtl/mjdcal_queue.sv @@
// ----------------------------------------------------------------------------
// mjdcal_queue: short item queue between front and back
// Register-based FIFO with wrap pointers and an occupancy count.
// ----------------------------------------------------------------------------
module mjdcal_queue
    import mjdcal_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_item  o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_qstat.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_qstat.empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ hw/rtl/mjdcal_back.sv @@
// ----------------------------------------------------------------------------
// mjdcal_back: date and time-of-day pipeline
// Nine stages. Each constant division is a reciprocal multiply in one stage
// and a single compare-and-correct step in the next. The time of day is split
// by multiplies by 24, 60 and 60 alongside. The last stage is the output.
// ----------------------------------------------------------------------------
module mjdcal_back
    import mjdcal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_qstat,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [31:0] o_second_fraction
);

    localparam int unsigned NSTG = 9;

    typedef struct packed {
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [31:0] sf;
    } t_tod;

    logic [NSTG-1:0] r_vld;
    logic            w_en;

    // stage A
    logic [21:0] r_a_z;
    logic        r_a_jul;
    logic [21:0] r_a_n1;
    logic [4:0]  r_a_qa;
    logic [36:0] r_a_t24;
    // stage B
    logic [21:0] r_b_c;
    logic [4:0]  r_b_hr;
    logic [37:0] r_b_tm;
    // stage C
    logic [21:0] r_c_c;
    logic [25:0] r_c_n2;
    logic [12:0] r_c_qd;
    logic [4:0]  r_c_hr;
    logic [5:0]  r_c_mn;
    logic [37:0] r_c_ts;
    // stage D
    logic [21:0] r_d_c;
    logic [12:0] r_d_d;
    t_tod        r_d_tod;
    // stage E
    logic [8:0]  r_e_ce;
    logic [12:0] r_e_d;
    t_tod        r_e_tod;
    // stage F
    logic [8:0]  r_f_ce;
    logic [12:0] r_f_d;
    logic [3:0]  r_f_qg;
    logic [22:0] r_f_n4;
    t_tod        r_f_tod;
    // stage G
    logic [8:0]  r_g_ce;
    logic [12:0] r_g_d;
    logic [3:0]  r_g_g;
    t_tod        r_g_tod;
    // stage H
    logic [8:0]  r_h_ce;
    logic [12:0] r_h_d;
    logic [3:0]  r_h_g;
    logic [8:0]  r_h_qm;
    logic [22:0] r_h_m5;
    t_tod        r_h_tod;
    // output stage
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    t_tod        r_o_tod;

    logic [23:0] w_n1_full;
    logic [21:0] w_n1;
    logic [36:0] w_pa;
    logic [36:0] w_t24;
    logic [21:0] w_ra;
    logic [4:0]  w_alpha;
    logic [21:0] w_b;
    logic [37:0] w_tm;
    logic [25:0] w_n2;
    logic [45:0] w_pd;
    logic [37:0] w_ts;
    logic [25:0] w_rd;
    logic [23:0] w_e_prod;
    logic [21:0] w_ce_full;
    logic [36:0] w_pg;
    logic [22:0] w_n4;
    logic [22:0] w_rg;
    logic [40:0] w_pm;
    logic [22:0] w_m5;
    logic [22:0] w_rm;
    logic [8:0]  w_q5;
    logic [8:0]  w_dom;
    logic [3:0]  w_mon;
    logic [12:0] w_yr;

    // hold the whole pipe while a result waits on a stalled output
    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_pop   = w_en && !i_qstat.empty;
    assign o_valid = r_vld[NSTG-1];

    always_comb begin
        // stage A: alpha estimate, hours
        w_n1_full = {i_item.z, 2'b00} - ALPHA_BIAS;
        w_n1      = i_item.jul ? '0 : w_n1_full[21:0];
        w_pa      = 37'(w_n1) * 37'(C_M1);
        w_t24     = 37'(i_item.frac) * 37'd24;
        // stage B: correct alpha, form C
        w_ra      = r_a_n1 - 22'(23'(r_a_qa) * 23'(ALPHA_DIV));
        w_alpha   = r_a_qa + 5'(w_ra >= 22'(ALPHA_DIV));
        w_b       = r_a_jul ? r_a_z
                            : r_a_z + 22'd1 + 22'(w_alpha) - 22'(w_alpha[4:2]);
        w_tm      = 38'(r_a_t24[31:0]) * 38'd60;
        // stage C: D estimate
        w_n2      = 26'(r_b_c) * 26'd20 - 26'(D_BIAS);
        w_pd      = 46'(w_n2) * 46'(C_M2);
        w_ts      = 38'(r_b_tm[31:0]) * 38'd60;
        // stage D: correct D
        w_rd      = r_c_n2 - 26'(r_c_qd) * 26'(D_DIV);
        // stage E: E and C - E
        w_e_prod  = 24'(r_d_d) * 24'd1461;
        w_ce_full = r_d_c - w_e_prod[23:2];
        // stage F: G estimate
        w_pg      = 37'(r_e_ce) * 37'(C_K4);
        w_n4      = 23'(r_e_ce) * 23'(G_MUL);
        // stage G: correct G
        w_rg      = r_f_n4 - 23'(r_f_qg) * 23'(G_DIV);
        // stage H: month-length estimate
        w_pm      = 41'(r_g_g) * C_K5;
        w_m5      = 23'(r_g_g) * 23'(G_DIV);
        // output stage: correct, day, month, year
        w_rm      = r_h_m5 - 23'(r_h_qm) * 23'(G_MUL);
        w_q5      = r_h_qm + 9'(w_rm >= 23'(G_MUL));
        w_dom     = r_h_ce - w_q5;
        w_mon     = (r_h_g < 4'd13) ? r_h_g - 4'd1 : r_h_g - 4'd13;
        w_yr      = (w_mon > 4'd2) ? r_h_d - 13'd4716 : r_h_d - 13'd4715;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_z      <= i_item.z;
            r_a_jul    <= i_item.jul;
            r_a_n1     <= w_n1;
            r_a_qa     <= w_pa[36:32];
            r_a_t24    <= w_t24;

            r_b_c      <= w_b + 22'(C_OFS);
            r_b_hr     <= r_a_t24[36:32];
            r_b_tm     <= w_tm;

            r_c_c      <= r_b_c;
            r_c_n2     <= w_n2;
            r_c_qd     <= w_pd[44:32];
            r_c_hr     <= r_b_hr;
            r_c_mn     <= r_b_tm[37:32];
            r_c_ts     <= w_ts;

            r_d_c      <= r_c_c;
            r_d_d      <= r_c_qd + 13'(w_rd >= 26'(D_DIV));
            r_d_tod.hr <= r_c_hr;
            r_d_tod.mn <= r_c_mn;
            r_d_tod.sc <= r_c_ts[37:32];
            r_d_tod.sf <= r_c_ts[31:0];

            r_e_ce     <= w_ce_full[8:0];
            r_e_d      <= r_d_d;
            r_e_tod    <= r_d_tod;

            r_f_ce     <= r_e_ce;
            r_f_d      <= r_e_d;
            r_f_qg     <= w_pg[35:32];
            r_f_n4     <= w_n4;
            r_f_tod    <= r_e_tod;

            r_g_ce     <= r_f_ce;
            r_g_d      <= r_f_d;
            r_g_g      <= r_f_qg + 4'(w_rg >= 23'(G_DIV));
            r_g_tod    <= r_f_tod;

            r_h_ce     <= r_g_ce;
            r_h_d      <= r_g_d;
            r_h_g      <= r_g_g;
            r_h_qm     <= w_pm[40:32];
            r_h_m5     <= w_m5;
            r_h_tod    <= r_g_tod;

            r_o_year   <= w_yr[11:0];
            r_o_month  <= w_mon;
            r_o_day    <= w_dom[4:0];
            r_o_tod    <= r_h_tod;
        end
    end

    assign o_year            = r_o_year;
    assign o_month           = r_o_month;
    assign o_day             = r_o_day;
    assign o_hour            = r_o_tod.hr;
    assign o_minute          = r_o_tod.mn;
    assign o_second          = r_o_tod.sc;
    assign o_second_fraction = r_o_tod.sf;

    // a reciprocal estimate is never more than one short
    a_alpha_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !r_a_jul |-> w_ra < 22'({ALPHA_DIV, 1'b0}))
        else $error("alpha estimate off by more than one");

    a_d_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> w_rd < 26'({D_DIV, 1'b0}))
        else $error("D estimate off by more than one");

    a_g_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> w_rg < 23'({G_DIV, 1'b0}))
        else $error("G estimate off by more than one");

endmodule

@@ hw/rtl/mjd_to_calendar_date_time_core.sv @@
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_time_core: MJD to calendar date and time of day
// Path: input stage register, item queue, then the nine back stages to the output.
// Throughput: one item per cycle unless stalled; the nine-stage back pipeline
// and input stage each take an item every cycle, decoupled by the item queue.
// Reset: synchronous, active low; clears the valid flags and queue pointers.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_time_core
    import mjdcal_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MJD_W-1:0]  i_mjd_day,
    input  logic [FRAC_W-1:0] i_day_fraction,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [11:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day,
    output logic [4:0]        o_hour,
    output logic [5:0]        o_minute,
    output logic [5:0]        o_second,
    output logic [31:0]       o_second_fraction
);

    t_qstat w_qstat;
    t_item  w_push_item;
    t_item  w_head_item;
    logic   w_push;
    logic   w_pop;

    mjdcal_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mjd_day      (i_mjd_day),
        .i_day_fraction (i_day_fraction),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    mjdcal_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_item  (w_head_item)
    );

    mjdcal_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_qstat           (w_qstat),
        .i_item            (w_head_item),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_year            (o_year),
        .o_month           (o_month),
        .o_day             (o_day),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second),
        .o_second_fraction (o_second_fraction)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the MJD to calendar date and time converter
// Drives MJD day and day-fraction items through the valid/stall handshake,
// predicts each calendar date and time of day, and compares every output
// field in order. A directed table comes first, then random items under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import mjdcal_pkg::*;

    localparam longint JD_OF_MJD0     = 2400001;
    localparam longint LAST_JULIAN_JD = 2299160;
    localparam int     RESET_CYCLES   = 9;
    localparam int     DRAIN_CYCLES   = 30;
    localparam int     CYCLE_LIMIT    = 200000;
    localparam int     ITEMS_PER_PHASE = 175;
    localparam int     NUM_PHASES     = 4;
    localparam int     JULIAN_EDGE_MJD = -100841;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] sub_second;
    } t_cal_time;

    typedef struct packed {
        logic signed [MJD_W-1:0] mjd;
        logic [FRAC_W-1:0]       frac;
        logic                    known;
        t_cal_time               date_time;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [MJD_W-1:0]  i_mjd_day = '0;
    logic [FRAC_W-1:0] i_day_fraction = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [11:0]       o_year;
    logic [3:0]        o_month;
    logic [4:0]        o_day;
    logic [4:0]        o_hour;
    logic [5:0]        o_minute;
    logic [5:0]        o_second;
    logic [31:0]       o_second_fraction;

    t_cal_time pending_dates[$];
    t_dir_row  dir_rows[$];
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        results_checked = 0;
    int        cycle_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    mjd_to_calendar_date_time_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mjd_day         (i_mjd_day),
        .i_day_fraction    (i_day_fraction),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_year            (o_year),
        .o_month           (o_month),
        .o_day             (o_day),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second),
        .o_second_fraction (o_second_fraction)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Meeus inverse Julian day with exact integer ratios, then split the day
    function automatic t_cal_time to_calendar(logic signed [MJD_W-1:0] mjd,
                                              logic [FRAC_W-1:0] frac);
        longint    jd, alpha, b, c, d, e, g, dom, mon, yr;
        logic [63:0] t;
        t_cal_time r;
        jd = longint'(mjd) + JD_OF_MJD0;
        if (jd > LAST_JULIAN_JD) begin
            alpha = (4 * jd - 7468865) / 146097;
            b = jd + 1 + alpha - alpha / 4;
        end else begin
            b = jd;
        end
        c   = b + 1524;
        d   = (20 * c - 2442) / 7305;
        e   = (1461 * d) / 4;
        g   = (10000 * (c - e)) / 306001;
        dom = c - e - (306001 * g) / 10000;
        mon = (g < 13) ? g - 1 : g - 13;
        yr  = (mon > 2) ? d - 4716 : d - 4715;
        r.year  = yr[11:0];
        r.month = mon[3:0];
        r.day   = dom[4:0];
        t = 64'(frac) * 64'd24;
        r.hour = t[36:32];
        t = 64'(t[31:0]) * 64'd60;
        r.minute = t[37:32];
        t = 64'(t[31:0]) * 64'd60;
        r.second = t[37:32];
        r.sub_second = t[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 field, got, want, results_checked);
        mismatch_count++;
    endtask

    // Hold the item until it is taken, then queue its expected date
    task automatic send_item(logic signed [MJD_W-1:0] mjd, logic [FRAC_W-1:0] frac,
                             logic known, t_cal_time typed);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mjd_day      <= mjd;
        i_day_fraction <= frac;
        do @(posedge i_clk); while (o_stall);
        pending_dates.push_back(known ? typed : to_calendar(mjd, frac));
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_cal_time want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                $display("UNEXPECTED result: %0d-%0d-%0d %0d:%0d:%0d", o_year, o_month,
                         o_day, o_hour, o_minute, o_second);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                if (o_year != want.year)   report_mismatch("year", o_year, want.year);
                if (o_month != want.month) report_mismatch("month", o_month, want.month);
                if (o_day != want.day)     report_mismatch("day", o_day, want.day);
                if (o_hour != want.hour)   report_mismatch("hour", o_hour, want.hour);
                if (o_minute != want.minute)
                    report_mismatch("minute", o_minute, want.minute);
                if (o_second != want.second)
                    report_mismatch("second", o_second, want.second);
                if (o_second_fraction != want.sub_second)
                    report_mismatch("second_fraction", o_second_fraction, want.sub_second);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_dates.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_cal_time none;
        logic signed [MJD_W-1:0] mjd;
        logic [FRAC_W-1:0] frac;
        none = '0;

        // Rows with a known date are typed in; the rest go through the predictor
        dir_rows.push_back('{19'sd0, 32'h0, 1'b1,
                             '{12'd1858, 4'd11, 5'd17, 5'd0, 6'd0, 6'd0, 32'd0}});
        dir_rows.push_back('{19'sd51544, 32'h8000_0000, 1'b1,
                             '{12'd2000, 4'd1, 5'd1, 5'd12, 6'd0, 6'd0, 32'd0}});
        // last Julian day, with the largest fraction
        dir_rows.push_back('{-19'sd100841, 32'hFFFF_FFFF, 1'b1,
                             '{12'd1582, 4'd10, 5'd4, 5'd23, 6'd59, 6'd59,
                               32'd4294880896}});
        // first Gregorian day
        dir_rows.push_back('{-19'sd100840, 32'h0, 1'b1,
                             '{12'd1582, 4'd10, 5'd15, 5'd0, 6'd0, 6'd0, 32'd0}});
        dir_rows.push_back('{-19'sd262144, 32'h0, 1'b0, none});
        dir_rows.push_back('{-19'sd262144, 32'hFFFF_FFFF, 1'b0, none});
        dir_rows.push_back('{19'sd262143, 32'h0, 1'b0, none});
        dir_rows.push_back('{19'sd262143, 32'hFFFF_FFFF, 1'b0, none});
        dir_rows.push_back('{-19'sd1, 32'h0000_0001, 1'b0, none});
        dir_rows.push_back('{19'sd1, 32'h7FFF_FFFF, 1'b0, none});
        dir_rows.push_back('{-19'sd100842, 32'h0AAA_AAAB, 1'b0, none});
        dir_rows.push_back('{-19'sd100839, 32'h0AAA_AAAA, 1'b0, none});
        dir_rows.push_back('{19'sd51603, 32'hAAAA_AAAA, 1'b0, none});
        dir_rows.push_back('{19'sd51604, 32'h5555_5555, 1'b0, none});
        dir_rows.push_back('{19'sd15078, 32'h002D_82D8, 1'b0, none});
        dir_rows.push_back('{19'sd15079, 32'hFFFE_AE40, 1'b0, none});
        dir_rows.push_back('{19'sd88127, 32'h1234_5678, 1'b0, none});
        dir_rows.push_back('{-19'sd94553, 32'hDEAD_BEEF, 1'b0, none});
        dir_rows.push_back('{-19'sd131000, 32'h0000_B60B, 1'b0, none});
        dir_rows.push_back('{19'sd51909, 32'hFFFF_0000, 1'b0, none});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].mjd, dir_rows[k].frac, dir_rows[k].known,
                      dir_rows[k].date_time);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(9) < 7)
                    mjd = MJD_W'($urandom);
                else
                    mjd = MJD_W'(JULIAN_EDGE_MJD + $urandom_range(128) - 64);
                case ($urandom_range(9))
                    0: frac = '0;
                    1: frac = '1;
                    2: frac = FRAC_W'(32'h0AAA_AAAB * $urandom_range(23) - $urandom_range(1));
                    default: frac = $urandom;
                endcase
                send_item(mjd, frac, 1'b0, none);
            end
            // Drain fully once before the next pattern
            if (phase == 1) begin
                while (pending_dates.size() != 0) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items (directed table, full MJD range, Julian edge)",
                 items_sent);
        $display("checked %0d results over %0d idle/stall patterns, %0d field errors",
                 results_checked, NUM_PHASES, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mjdcal_pkg.sv
hw/rtl/mjdcal_front.sv
hw/rtl/mjdcal_queue.sv
hw/rtl/mjdcal_back.sv
hw/rtl/mjd_to_calendar_date_time_core.sv
tb/sv/tb_top.sv
